@@ design/bsd_pkg.sv @@
// Shared types, constants and helpers for the 24-bit BMP stream decoder.
package bsd_pkg;

	// Image limits and derived widths
	localparam int MAX_DIMENSION = 4096;
	localparam int DIM_W         = $clog2(MAX_DIMENSION + 1);
	localparam int COORD_W       = 12;
	localparam int HEADER_LEN    = 54;
	localparam int POS_W         = 6;
	localparam int WORD_W        = 32;
	localparam int DIV_CNT_W     = $clog2(WORD_W);
	localparam int TOKQ_DEPTH    = 4;
	localparam int TOKQ_AW       = $clog2(TOKQ_DEPTH);

	// Header constants
	localparam logic [7:0]        MAGIC_0     = 8'h42;  // 'B'
	localparam logic [7:0]        MAGIC_1     = 8'h4D;  // 'M'
	localparam logic [WORD_W-1:0] INFO_SIZE   = 32'd40;
	localparam logic [15:0]       PLANES_ONE  = 16'd1;
	localparam logic [15:0]       DEPTH_24    = 16'd24;

	// Byte offsets of the header fields
	localparam logic [POS_W-1:0] OFS_TOTAL_SIZE = 6'd2;
	localparam logic [POS_W-1:0] OFS_DATA_OFS   = 6'd10;
	localparam logic [POS_W-1:0] OFS_HDR_SIZE   = 6'd14;
	localparam logic [POS_W-1:0] OFS_WIDTH      = 6'd18;
	localparam logic [POS_W-1:0] OFS_HEIGHT     = 6'd22;
	localparam logic [POS_W-1:0] OFS_PLANES     = 6'd26;
	localparam logic [POS_W-1:0] OFS_BPP        = 6'd28;
	localparam logic [POS_W-1:0] OFS_COMP       = 6'd30;
	localparam logic [POS_W-1:0] OFS_PSIZE      = 6'd34;

	// Result status codes
	localparam logic [2:0] ST_PIXEL     = 3'd0;
	localparam logic [2:0] ST_MAGIC     = 3'd1;
	localparam logic [2:0] ST_SIZE      = 3'd2;
	localparam logic [2:0] ST_HDR_SIZE  = 3'd3;
	localparam logic [2:0] ST_COMP      = 3'd4;
	localparam logic [2:0] ST_PLANES    = 3'd5;
	localparam logic [2:0] ST_DEPTH     = 3'd6;
	localparam logic [2:0] ST_GEOMETRY  = 3'd7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
	} item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic               last_pixel;
	} result_t;

	typedef enum logic [2:0] {
		F_WAIT,
		F_HEADER,
		F_CHECK,
		F_DIVIDE,
		F_GEOM,
		F_STREAM
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_PIXELS,
		B_PAD
	} back_state_t;

	typedef enum logic [1:0] {
		TK_DATA,
		TK_ERR,
		TK_HDR
	} tok_kind_t;

	// Request passed from the parser to the pixel assembler
	typedef struct packed {
		tok_kind_t        kind;
		logic [2:0]       code;
		logic [7:0]       data;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic             inverted;
		logic [1:0]       padding;
	} token_t;

	// Drop one byte into a little-endian 32-bit word
	function automatic logic [WORD_W-1:0] put_lane(input logic [WORD_W-1:0] word,
			input logic [1:0] lane, input logic [7:0] b);
		logic [WORD_W-1:0] w;
		w = word;
		case (lane)
			2'd0: w[7:0]   = b;
			2'd1: w[15:8]  = b;
			2'd2: w[23:16] = b;
			2'd3: w[31:24] = b;
			default: w = word;
		endcase
		return w;
	endfunction

endpackage

@@ design/bsd_div.sv @@
// Restoring divider, one quotient bit per cycle, for the row-stride check.
module bsd_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [bsd_pkg::WORD_W-1:0]     dividend,
	input  logic [bsd_pkg::DIM_W-1:0]      divisor,
	output logic                           done,
	output logic [bsd_pkg::WORD_W-1:0]     quotient
);

	logic                             busy_q;
	logic                             done_q;
	logic [bsd_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [bsd_pkg::WORD_W-1:0]       quot_q;
	logic [bsd_pkg::DIM_W-1:0]        rem_q;
	logic [bsd_pkg::DIM_W-1:0]        dsr_q;
	logic [bsd_pkg::DIM_W:0]          rem_sh;
	logic [bsd_pkg::DIM_W:0]          rem_sub;
	logic                             fits;

	// Trial subtract of the shifted remainder
	assign rem_sh  = {rem_q, quot_q[bsd_pkg::WORD_W-1]};
	assign fits    = rem_sh >= {1'b0, dsr_q};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	assign done     = done_q;
	assign quotient = quot_q;

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= bsd_pkg::DIV_CNT_W'(bsd_pkg::WORD_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Quotient and remainder datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[bsd_pkg::WORD_W-2:0], fits};
			rem_q  <= fits ? rem_sub[bsd_pkg::DIM_W-1:0] : rem_sh[bsd_pkg::DIM_W-1:0];
		end
	end

`ifndef NO_ASSERTIONS
	// done is a single pulse right after the last iteration
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("divider done without a finished run");
	// a new run is never launched over a running one
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");
`endif

endmodule

@@ design/bsd_front.sv @@
// Front end: header capture, header checks and classification of file bytes.
module bsd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  bsd_pkg::item_t    item,
	output logic              tok_push,
	output bsd_pkg::token_t   tok,
	input  logic              tok_full
);

	bsd_pkg::front_state_t          state_q, state_d;
	logic [bsd_pkg::POS_W-1:0]      pos_q, pos_d;
	logic [bsd_pkg::POS_W-1:0]      hdr_pos;
	logic [1:0]                     lane;
	logic                           accept;
	logic                           in_header;

	logic [7:0]                     byte0_q;
	logic [bsd_pkg::WORD_W-1:0]     total_size_q;
	logic [bsd_pkg::WORD_W-1:0]     data_ofs_q;
	logic [bsd_pkg::WORD_W-1:0]     hdr_size_q;
	logic [bsd_pkg::WORD_W-1:0]     width_raw_q;
	logic [bsd_pkg::WORD_W-1:0]     height_raw_q;
	logic [bsd_pkg::WORD_W-1:0]     comp_q;
	logic [bsd_pkg::WORD_W-1:0]     psize_q;
	logic [15:0]                    planes_q;
	logic [15:0]                    bpp_q;
	logic [bsd_pkg::DIM_W-1:0]      width_q;
	logic [bsd_pkg::DIM_W-1:0]      height_q;
	logic                           inverted_q;

	logic [bsd_pkg::WORD_W-1:0]     width_mag;
	logic [bsd_pkg::WORD_W-1:0]     height_mag;
	logic [bsd_pkg::WORD_W-1:0]     size_sum;
	logic [2:0]                     check_code;

	logic                           div_start;
	logic                           div_done;
	logic [bsd_pkg::WORD_W-1:0]     quot;
	logic [bsd_pkg::DIM_W+1:0]      width_x3;
	logic [bsd_pkg::WORD_W-1:0]     stride_diff;
	logic                           geom_bad;

	// Input is held off while checking and whenever the request queue is full
	assign full = (state_q == bsd_pkg::F_CHECK) || (state_q == bsd_pkg::F_DIVIDE) ||
			(state_q == bsd_pkg::F_GEOM) || tok_full;
	assign accept    = push && !full;
	assign in_header = item.start_of_file || (state_q == bsd_pkg::F_HEADER);
	assign hdr_pos   = item.start_of_file ? '0 : pos_q;
	assign lane      = hdr_pos[1:0] - 2'd2;

	// Header checks, in priority order
	assign width_mag  = width_raw_q[bsd_pkg::WORD_W-1]  ? (~width_raw_q + 1'b1)  : width_raw_q;
	assign height_mag = height_raw_q[bsd_pkg::WORD_W-1] ? (~height_raw_q + 1'b1) : height_raw_q;
	assign size_sum   = psize_q + data_ofs_q;

	always_comb begin
		if (size_sum != total_size_q)
			check_code = bsd_pkg::ST_SIZE;
		else if (hdr_size_q != bsd_pkg::INFO_SIZE)
			check_code = bsd_pkg::ST_HDR_SIZE;
		else if (comp_q != '0)
			check_code = bsd_pkg::ST_COMP;
		else if (planes_q != bsd_pkg::PLANES_ONE)
			check_code = bsd_pkg::ST_PLANES;
		else if (bpp_q != bsd_pkg::DEPTH_24)
			check_code = bsd_pkg::ST_DEPTH;
		else if (width_mag == '0 || height_mag == '0 ||
				width_mag > bsd_pkg::WORD_W'(bsd_pkg::MAX_DIMENSION) ||
				height_mag > bsd_pkg::WORD_W'(bsd_pkg::MAX_DIMENSION))
			check_code = bsd_pkg::ST_GEOMETRY;
		else
			check_code = bsd_pkg::ST_PIXEL;
	end

	// Row stride: quotient minus three bytes per pixel must land in 0..3
	assign width_x3    = (bsd_pkg::DIM_W+2)'(width_q) + (bsd_pkg::DIM_W+2)'({width_q, 1'b0});
	assign stride_diff = quot - bsd_pkg::WORD_W'(width_x3);
	assign geom_bad    = (quot < bsd_pkg::WORD_W'(width_x3)) || (stride_diff > 32'd3);

	bsd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (psize_q),
		.divisor  (height_mag[bsd_pkg::DIM_W-1:0]),
		.done     (div_done),
		.quotient (quot)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsd_pkg::F_WAIT;
			pos_q   <= '0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
		end
	end

	// Next state and requests to the back end
	always_comb begin
		state_d      = state_q;
		pos_d        = pos_q;
		tok_push     = 1'b0;
		div_start    = 1'b0;
		tok          = '0;
		tok.kind     = bsd_pkg::TK_DATA;
		tok.code     = bsd_pkg::ST_PIXEL;
		tok.data     = item.data_byte;
		tok.width    = width_q;
		tok.height   = height_q;
		tok.inverted = inverted_q;
		tok.padding  = stride_diff[1:0];
		case (state_q)
			bsd_pkg::F_WAIT, bsd_pkg::F_HEADER, bsd_pkg::F_STREAM: begin
				if (accept) begin
					if (in_header) begin
						pos_d   = hdr_pos + 1'b1;
						state_d = bsd_pkg::F_HEADER;
						if (hdr_pos == bsd_pkg::POS_W'(1) &&
								(byte0_q != bsd_pkg::MAGIC_0 ||
								item.data_byte != bsd_pkg::MAGIC_1)) begin
							tok_push = 1'b1;
							tok.kind = bsd_pkg::TK_ERR;
							tok.code = bsd_pkg::ST_MAGIC;
							state_d  = bsd_pkg::F_WAIT;
						end else if (hdr_pos == bsd_pkg::POS_W'(bsd_pkg::HEADER_LEN - 1)) begin
							state_d = bsd_pkg::F_CHECK;
						end
					end else if (state_q == bsd_pkg::F_STREAM) begin
						tok_push = 1'b1;
					end
				end
			end
			bsd_pkg::F_CHECK: begin
				if (check_code != bsd_pkg::ST_PIXEL) begin
					if (!tok_full) begin
						tok_push = 1'b1;
						tok.kind = bsd_pkg::TK_ERR;
						tok.code = check_code;
						state_d  = bsd_pkg::F_WAIT;
					end
				end else begin
					div_start = 1'b1;
					state_d   = bsd_pkg::F_DIVIDE;
				end
			end
			bsd_pkg::F_DIVIDE: begin
				if (div_done)
					state_d = bsd_pkg::F_GEOM;
			end
			bsd_pkg::F_GEOM: begin
				if (!tok_full) begin
					tok_push = 1'b1;
					if (geom_bad) begin
						tok.kind = bsd_pkg::TK_ERR;
						tok.code = bsd_pkg::ST_GEOMETRY;
						state_d  = bsd_pkg::F_WAIT;
					end else begin
						tok.kind = bsd_pkg::TK_HDR;
						state_d  = bsd_pkg::F_STREAM;
					end
				end
			end
			default: state_d = bsd_pkg::F_WAIT;
		endcase
	end

	// Header field capture, little-endian byte lanes
	always_ff @(posedge clk) begin
		if (accept && in_header) begin
			if (hdr_pos == '0)
				byte0_q <= item.data_byte;
			if (hdr_pos inside {[bsd_pkg::OFS_TOTAL_SIZE : bsd_pkg::OFS_TOTAL_SIZE + 6'd3]})
				total_size_q <= bsd_pkg::put_lane(total_size_q, lane, item.data_byte);
			if (hdr_pos inside {[bsd_pkg::OFS_DATA_OFS : bsd_pkg::OFS_DATA_OFS + 6'd3]})
				data_ofs_q <= bsd_pkg::put_lane(data_ofs_q, lane, item.data_byte);
			if (hdr_pos inside {[bsd_pkg::OFS_HDR_SIZE : bsd_pkg::OFS_HDR_SIZE + 6'd3]})
				hdr_size_q <= bsd_pkg::put_lane(hdr_size_q, lane, item.data_byte);
			if (hdr_pos inside {[bsd_pkg::OFS_WIDTH : bsd_pkg::OFS_WIDTH + 6'd3]})
				width_raw_q <= bsd_pkg::put_lane(width_raw_q, lane, item.data_byte);
			if (hdr_pos inside {[bsd_pkg::OFS_HEIGHT : bsd_pkg::OFS_HEIGHT + 6'd3]})
				height_raw_q <= bsd_pkg::put_lane(height_raw_q, lane, item.data_byte);
			if (hdr_pos inside {[bsd_pkg::OFS_COMP : bsd_pkg::OFS_COMP + 6'd3]})
				comp_q <= bsd_pkg::put_lane(comp_q, lane, item.data_byte);
			if (hdr_pos inside {[bsd_pkg::OFS_PSIZE : bsd_pkg::OFS_PSIZE + 6'd3]})
				psize_q <= bsd_pkg::put_lane(psize_q, lane, item.data_byte);
			if (hdr_pos inside {[bsd_pkg::OFS_PLANES : bsd_pkg::OFS_PLANES + 6'd1]}) begin
				if (hdr_pos[0])
					planes_q[15:8] <= item.data_byte;
				else
					planes_q[7:0] <= item.data_byte;
			end
			if (hdr_pos inside {[bsd_pkg::OFS_BPP : bsd_pkg::OFS_BPP + 6'd1]}) begin
				if (hdr_pos[0])
					bpp_q[15:8] <= item.data_byte;
				else
					bpp_q[7:0] <= item.data_byte;
			end
		end
	end

	// Image geometry, latched in the field-check state
	always_ff @(posedge clk) begin
		if (state_q == bsd_pkg::F_CHECK) begin
			width_q    <= width_mag[bsd_pkg::DIM_W-1:0];
			height_q   <= height_mag[bsd_pkg::DIM_W-1:0];
			inverted_q <= height_raw_q[bsd_pkg::WORD_W-1];
		end
	end

`ifndef NO_ASSERTIONS
	// every error request ends the file
	a_err_to_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_push && tok.kind == bsd_pkg::TK_ERR) |=> state_q == bsd_pkg::F_WAIT)
		else $error("parser kept running after an error");
	// the divider only finishes while the parser waits on it
	a_div_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == bsd_pkg::F_DIVIDE)
		else $error("divider result outside the divide state");
	// a request is never offered into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		tok_push |-> !tok_full)
		else $error("request pushed into a full queue");
`endif

endmodule

@@ design/bsd_tokq.sv @@
// Four-entry request queue between the parser and the pixel assembler.
module bsd_tokq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  bsd_pkg::token_t   wdata,
	input  logic              pop,
	output logic              empty,
	output bsd_pkg::token_t   rdata
);

	bsd_pkg::token_t                 mem_q [bsd_pkg::TOKQ_DEPTH];
	logic [bsd_pkg::TOKQ_AW-1:0]     wp_q;
	logic [bsd_pkg::TOKQ_AW-1:0]     rp_q;
	logic [bsd_pkg::TOKQ_AW:0]       cnt_q;
	logic                            do_push;
	logic                            do_pop;

	assign full    = cnt_q == (bsd_pkg::TOKQ_AW+1)'(bsd_pkg::TOKQ_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wp_q <= wp_q + 1'b1;
			if (do_pop)
				rp_q <= rp_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wp_q] <= wdata;
	end

endmodule

@@ design/bsd_back.sv @@
// Back end: assembles pixels from byte requests, skips row padding, buffers results.
module bsd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_empty,
	output logic              tok_pop,
	input  bsd_pkg::token_t   tok,
	output logic              empty,
	input  logic              pop,
	output bsd_pkg::result_t  result
);

	bsd_pkg::back_state_t         phase_q, phase_d;
	logic [bsd_pkg::DIM_W-1:0]    col_q, col_d;
	logic [bsd_pkg::DIM_W-1:0]    row_q, row_d;
	logic [1:0]                   bip_q, bip_d;
	logic [1:0]                   pad_left_q, pad_left_d;
	logic [bsd_pkg::DIM_W-1:0]    width_q;
	logic [bsd_pkg::DIM_W-1:0]    height_q;
	logic                         inverted_q;
	logic [1:0]                   padding_q;
	logic [7:0]                   blue_q;
	logic [7:0]                   green_q;

	logic [bsd_pkg::DIM_W-1:0]    col_inc;
	logic [bsd_pkg::DIM_W-1:0]    row_inc;
	logic [bsd_pkg::DIM_W-1:0]    row_out;
	logic                         take;
	logic                         emit;
	bsd_pkg::result_t             res;

	bsd_pkg::result_t             ob_q [2];
	logic                         ob_wp_q;
	logic                         ob_rp_q;
	logic [1:0]                   ob_cnt_q;
	logic                         ob_pop;

	// One request per cycle while the result buffer has room
	assign take    = !tok_empty && (ob_cnt_q != 2'd2);
	assign tok_pop = take;

	assign col_inc = col_q + 1'b1;
	assign row_inc = row_q + 1'b1;
	assign row_out = inverted_q ? (height_q - 1'b1 - row_q) : row_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= bsd_pkg::B_IDLE;
			col_q      <= '0;
			row_q      <= '0;
			bip_q      <= '0;
			pad_left_q <= '0;
		end else begin
			phase_q    <= phase_d;
			col_q      <= col_d;
			row_q      <= row_d;
			bip_q      <= bip_d;
			pad_left_q <= pad_left_d;
		end
	end

	// Request decode and pixel counting
	always_comb begin
		phase_d    = phase_q;
		col_d      = col_q;
		row_d      = row_q;
		bip_d      = bip_q;
		pad_left_d = pad_left_q;
		emit       = 1'b0;
		res        = '0;
		if (take) begin
			case (tok.kind)
				bsd_pkg::TK_HDR: begin
					phase_d    = bsd_pkg::B_PIXELS;
					col_d      = '0;
					row_d      = '0;
					bip_d      = '0;
					pad_left_d = '0;
				end
				bsd_pkg::TK_ERR: begin
					emit       = 1'b1;
					res.status = tok.code;
					phase_d    = bsd_pkg::B_IDLE;
				end
				bsd_pkg::TK_DATA: begin
					case (phase_q)
						bsd_pkg::B_PIXELS: begin
							case (bip_q)
								2'd0: bip_d = 2'd1;
								2'd1: bip_d = 2'd2;
								default: begin
									emit           = 1'b1;
									res.status     = bsd_pkg::ST_PIXEL;
									res.column     = bsd_pkg::COORD_W'(col_q);
									res.row        = bsd_pkg::COORD_W'(row_out);
									res.red        = tok.data;
									res.green      = green_q;
									res.blue       = blue_q;
									res.last_pixel = (row_inc == height_q) &&
											(col_inc == width_q);
									bip_d = 2'd0;
									if (col_inc >= width_q) begin
										col_d = '0;
										if (padding_q != 2'd0) begin
											pad_left_d = padding_q;
											phase_d    = bsd_pkg::B_PAD;
										end else begin
											row_d   = row_inc;
											phase_d = (row_inc >= height_q) ?
													bsd_pkg::B_IDLE : bsd_pkg::B_PIXELS;
										end
									end else begin
										col_d = col_inc;
									end
								end
							endcase
						end
						bsd_pkg::B_PAD: begin
							pad_left_d = pad_left_q - 1'b1;
							if (pad_left_q == 2'd1) begin
								row_d   = row_inc;
								phase_d = (row_inc >= height_q) ?
										bsd_pkg::B_IDLE : bsd_pkg::B_PIXELS;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// Geometry and held colour bytes
	always_ff @(posedge clk) begin
		if (take && tok.kind == bsd_pkg::TK_HDR) begin
			width_q    <= tok.width;
			height_q   <= tok.height;
			inverted_q <= tok.inverted;
			padding_q  <= tok.padding;
		end
		if (take && tok.kind == bsd_pkg::TK_DATA && phase_q == bsd_pkg::B_PIXELS) begin
			if (bip_q == 2'd0)
				blue_q <= tok.data;
			if (bip_q == 2'd1)
				green_q <= tok.data;
		end
	end

	// Two-entry result buffer
	assign empty  = ob_cnt_q == 2'd0;
	assign ob_pop = pop && !empty;
	assign result = ob_q[ob_rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wp_q  <= 1'b0;
			ob_rp_q  <= 1'b0;
			ob_cnt_q <= 2'd0;
		end else begin
			if (emit)
				ob_wp_q <= ~ob_wp_q;
			if (ob_pop)
				ob_rp_q <= ~ob_rp_q;
			if (emit && !ob_pop)
				ob_cnt_q <= ob_cnt_q + 1'b1;
			else if (ob_pop && !emit)
				ob_cnt_q <= ob_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			ob_q[ob_wp_q] <= res;
	end

`ifndef NO_ASSERTIONS
	// the final pixel always leaves the pixel phase
	a_last_leaves_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && res.last_pixel) |=> phase_q != bsd_pkg::B_PIXELS)
		else $error("pixels continue after the last pixel");
	// a new image starts at the top-left corner
	a_hdr_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(take && tok.kind == bsd_pkg::TK_HDR) |=>
		phase_q == bsd_pkg::B_PIXELS && col_q == '0 && row_q == '0 && bip_q == 2'd0)
		else $error("image start did not reset counters");
	// result buffer never holds more than two entries
	a_ob_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ob_cnt_q != 2'd3)
		else $error("result buffer overfilled");
`endif

endmodule

@@ design/bmp24_stream_decoder.sv @@
// Top level of the 24-bit BMP stream decoder: parser, request queue, pixel assembler.
//
//  Channel   Handshake        Payload             Moves
//  input     push / full      item  (item_t)      one file byte per request
//  output    pop / empty      result (result_t)   one pixel or one error per request
//
//  Header and pixel bytes are taken one per cycle while full is low.
//  After the 54th header byte full stays high through the field checks, the bit-serial
//  divider (32 quotient bits, then its done pulse) and the stride check; a failed field
//  check sends its error request and releases full without running the divider.
//  full also rises when the four-entry request queue fills behind a stalled output;
//  results sit in a two-entry buffer, so a full cycle of pops keeps bytes flowing.
//  arst_n clears all control state; the parser then waits for start_of_file.
module bmp24_stream_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  bsd_pkg::item_t    item,
	output logic              empty,
	input  logic              pop,
	output bsd_pkg::result_t  result
);

	logic              tok_push;
	logic              tok_full;
	logic              tok_pop;
	logic              tok_empty;
	bsd_pkg::token_t   tok_in;
	bsd_pkg::token_t   tok_out;

	bsd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.tok_push (tok_push),
		.tok      (tok_in),
		.tok_full (tok_full)
	);

	bsd_tokq u_tokq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (tok_push),
		.full   (tok_full),
		.wdata  (tok_in),
		.pop    (tok_pop),
		.empty  (tok_empty),
		.rdata  (tok_out)
	);

	bsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_empty (tok_empty),
		.tok_pop   (tok_pop),
		.tok       (tok_out),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

@@ verif/tb_bmp24_stream_decoder.sv @@
// Self-checking testbench for the 24-bit BMP stream decoder.
`timescale 1ns / 1ps

module tb_bmp24_stream_decoder;

	localparam int RANDOM_BYTES   = 240;
	localparam int DRAIN_LIMIT    = 200000;
	localparam int SETTLE_CYCLES  = 64;
	localparam int RUN_LIMIT_NS   = 50_000_000;

	// Decoder phases as tracked by the predictor
	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_HEADER,
		SCAN_PIXELS,
		SCAN_PADDING
	} scan_phase_t;

	// Ways a random file can be spoiled
	typedef enum int {
		DF_NONE,
		DF_MAGIC,
		DF_SIZE,
		DF_INFO,
		DF_COMP,
		DF_PLANES,
		DF_DEPTH,
		DF_DIM,
		DF_STRIDE,
		DF_CUT,
		DF_NOISE
	} defect_t;

	// Header fields of one generated file
	typedef struct {
		logic [7:0]  magic0;
		logic [7:0]  magic1;
		logic [31:0] total_size;
		logic [31:0] data_ofs;
		logic [31:0] info_size;
		logic [31:0] width;
		logic [31:0] height;
		logic [15:0] planes;
		logic [15:0] bpp;
		logic [31:0] comp;
		logic [31:0] psize;
	} bmp_hdr_t;

	logic             clk    = 1'b0;
	logic             arst_n = 1'b0;
	logic             push   = 1'b0;
	logic             full;
	bsd_pkg::item_t   item   = '0;
	logic             empty;
	logic             pop    = 1'b0;
	bsd_pkg::result_t result;

	bmp24_stream_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state
	scan_phase_t                scan_phase = SCAN_IDLE;
	logic [bsd_pkg::POS_W-1:0]  hdr_pos    = '0;
	logic [7:0]                 hdr_seen [bsd_pkg::HEADER_LEN];
	int unsigned                img_w      = 0;
	int unsigned                img_h      = 0;
	bit                         rows_flip  = 1'b0;
	int unsigned                row_pad    = 0;
	int unsigned                pad_left   = 0;
	int unsigned                col_cnt    = 0;
	int unsigned                row_cnt    = 0;
	int unsigned                pix_byte   = 0;
	logic [7:0]                 held_b     = '0;
	logic [7:0]                 held_g     = '0;

	bsd_pkg::result_t pending_results [$];

	int failures       = 0;
	int bytes_taken    = 0;
	int bytes_sent     = 0;
	int files_sent     = 0;
	int pixels_checked = 0;
	int errors_checked = 0;
	int burst_left     = 0;
	int rx_mode        = 0;
	int rx_left        = 0;

	function automatic logic [31:0] hdr_word(input logic [bsd_pkg::POS_W-1:0] at);
		return {hdr_seen[at + 6'd3], hdr_seen[at + 6'd2], hdr_seen[at + 6'd1], hdr_seen[at]};
	endfunction

	// Header checks in priority order; latches geometry when all pass
	function automatic logic [2:0] header_verdict();
		logic [31:0] fsize, dofs, hsz, wraw, hraw, comp, psz, w, h, sum;
		logic [15:0] planes, bpp;
		logic [63:0] quot, w3;
		fsize  = hdr_word(bsd_pkg::OFS_TOTAL_SIZE);
		dofs   = hdr_word(bsd_pkg::OFS_DATA_OFS);
		hsz    = hdr_word(bsd_pkg::OFS_HDR_SIZE);
		wraw   = hdr_word(bsd_pkg::OFS_WIDTH);
		hraw   = hdr_word(bsd_pkg::OFS_HEIGHT);
		planes = {hdr_seen[bsd_pkg::OFS_PLANES + 6'd1], hdr_seen[bsd_pkg::OFS_PLANES]};
		bpp    = {hdr_seen[bsd_pkg::OFS_BPP + 6'd1], hdr_seen[bsd_pkg::OFS_BPP]};
		comp   = hdr_word(bsd_pkg::OFS_COMP);
		psz    = hdr_word(bsd_pkg::OFS_PSIZE);
		sum    = psz + dofs;
		if (sum != fsize) return bsd_pkg::ST_SIZE;
		if (hsz != bsd_pkg::INFO_SIZE) return bsd_pkg::ST_HDR_SIZE;
		if (comp != '0) return bsd_pkg::ST_COMP;
		if (planes != bsd_pkg::PLANES_ONE) return bsd_pkg::ST_PLANES;
		if (bpp != bsd_pkg::DEPTH_24) return bsd_pkg::ST_DEPTH;
		// most negative value keeps its sign bit and so counts as oversize
		w = wraw[31] ? (~wraw + 32'd1) : wraw;
		h = hraw[31] ? (~hraw + 32'd1) : hraw;
		if (w == '0 || h == '0) return bsd_pkg::ST_GEOMETRY;
		if (w > 32'(bsd_pkg::MAX_DIMENSION) || h > 32'(bsd_pkg::MAX_DIMENSION))
			return bsd_pkg::ST_GEOMETRY;
		quot = {32'd0, psz} / {32'd0, h};
		w3   = {32'd0, w} * 64'd3;
		if (quot < w3 || quot - w3 > 64'd3) return bsd_pkg::ST_GEOMETRY;
		img_w     = w;
		img_h     = h;
		rows_flip = hraw[31];
		row_pad   = 32'(quot - w3);
		return bsd_pkg::ST_PIXEL;
	endfunction

	function automatic void post_error(logic [2:0] code);
		bsd_pkg::result_t r;
		r        = '0;
		r.status = code;
		pending_results.push_back(r);
		scan_phase = SCAN_IDLE;
	endfunction

	function automatic void close_row();
		row_cnt++;
		scan_phase = (row_cnt >= img_h) ? SCAN_IDLE : SCAN_PIXELS;
	endfunction

	// Advances the predictor by one accepted byte; returns 0 if the byte is ignored
	function automatic bit decode_byte(bsd_pkg::item_t it);
		bsd_pkg::result_t r;
		logic [2:0]       code;
		int unsigned      rv;
		if (it.start_of_file) begin
			scan_phase = SCAN_HEADER;
			hdr_pos    = '0;
		end
		case (scan_phase)
			SCAN_HEADER: begin
				hdr_seen[hdr_pos] = it.data_byte;
				hdr_pos++;
				if (hdr_pos == 6'd2 && (hdr_seen[0] != bsd_pkg::MAGIC_0 ||
						hdr_seen[1] != bsd_pkg::MAGIC_1)) begin
					post_error(bsd_pkg::ST_MAGIC);
				end else if (hdr_pos == bsd_pkg::POS_W'(bsd_pkg::HEADER_LEN)) begin
					code = header_verdict();
					if (code != bsd_pkg::ST_PIXEL) begin
						post_error(code);
					end else begin
						scan_phase = SCAN_PIXELS;
						col_cnt    = 0;
						row_cnt    = 0;
						pix_byte   = 0;
						pad_left   = 0;
					end
				end
			end
			SCAN_PIXELS: begin
				if (pix_byte == 0) begin
					held_b   = it.data_byte;
					pix_byte = 1;
				end else if (pix_byte == 1) begin
					held_g   = it.data_byte;
					pix_byte = 2;
				end else begin
					rv           = rows_flip ? (img_h - 1 - row_cnt) : row_cnt;
					r.status     = bsd_pkg::ST_PIXEL;
					r.column     = col_cnt[bsd_pkg::COORD_W-1:0];
					r.row        = rv[bsd_pkg::COORD_W-1:0];
					r.red        = it.data_byte;
					r.green      = held_g;
					r.blue       = held_b;
					r.last_pixel = (row_cnt + 1 == img_h) && (col_cnt + 1 == img_w);
					pending_results.push_back(r);
					pix_byte = 0;
					col_cnt++;
					if (col_cnt >= img_w) begin
						col_cnt = 0;
						if (row_pad > 0) begin
							pad_left   = row_pad;
							scan_phase = SCAN_PADDING;
						end else begin
							close_row();
						end
					end
				end
			end
			SCAN_PADDING: begin
				if (pad_left > 0) pad_left--;
				if (pad_left == 0) close_row();
			end
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	// One request per byte; bursts with random gaps in between
	task automatic send_byte(input logic [7:0] b, input logic sof);
		bsd_pkg::item_t it;
		int             gap;
		it.data_byte     = b;
		it.start_of_file = sof;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
				: $urandom_range(1, 24);
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		bytes_sent++;
		if (decode_byte(it)) bytes_taken++;
	endtask

	// Header (first head_len bytes) followed by tail_len random bytes
	task automatic send_file(input bmp_hdr_t d, input int head_len, input int tail_len);
		logic [7:0] hb [bsd_pkg::HEADER_LEN];
		int k;
		foreach (hb[i]) hb[i] = 8'($urandom);
		hb[0] = d.magic0;
		hb[1] = d.magic1;
		for (k = 0; k < 4; k++) begin
			hb[bsd_pkg::OFS_TOTAL_SIZE + 6'(k)] = d.total_size[8*k +: 8];
			hb[bsd_pkg::OFS_DATA_OFS + 6'(k)]   = d.data_ofs[8*k +: 8];
			hb[bsd_pkg::OFS_HDR_SIZE + 6'(k)]   = d.info_size[8*k +: 8];
			hb[bsd_pkg::OFS_WIDTH + 6'(k)]      = d.width[8*k +: 8];
			hb[bsd_pkg::OFS_HEIGHT + 6'(k)]     = d.height[8*k +: 8];
			hb[bsd_pkg::OFS_COMP + 6'(k)]       = d.comp[8*k +: 8];
			hb[bsd_pkg::OFS_PSIZE + 6'(k)]      = d.psize[8*k +: 8];
		end
		for (k = 0; k < 2; k++) begin
			hb[bsd_pkg::OFS_PLANES + 6'(k)] = d.planes[8*k +: 8];
			hb[bsd_pkg::OFS_BPP + 6'(k)]    = d.bpp[8*k +: 8];
		end
		for (k = 0; k < head_len; k++) send_byte(hb[6'(k)], k == 0);
		for (k = 0; k < tail_len; k++) send_byte(8'($urandom), 1'b0);
		if (head_len > 0) files_sent++;
	endtask

	function automatic bmp_hdr_t good_header(int unsigned w, int unsigned h, int unsigned pad,
			bit flip_w, bit flip_h);
		bmp_hdr_t d;
		d.magic0     = bsd_pkg::MAGIC_0;
		d.magic1     = bsd_pkg::MAGIC_1;
		d.info_size  = bsd_pkg::INFO_SIZE;
		d.planes     = bsd_pkg::PLANES_ONE;
		d.bpp        = bsd_pkg::DEPTH_24;
		d.comp       = '0;
		d.width      = flip_w ? (~w + 1) : w;
		d.height     = flip_h ? (~h + 1) : h;
		d.psize      = h * (3 * w + pad);
		d.data_ofs   = bsd_pkg::HEADER_LEN;
		d.total_size = d.psize + d.data_ofs;
		return d;
	endfunction

	function automatic int image_bytes(int unsigned w, int unsigned h, int unsigned pad);
		return h * (3 * w + pad);
	endfunction

	// Receiver: pop pattern switches between streaming, random, slow and periodic
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(8, 120);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				2: pop <= ($urandom_range(0, 7) == 0);
				default: pop <= rx_left[2];
			endcase
		end
	end

	function automatic bit field_differs(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v === act_v) return 1'b0;
		$display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
		return 1'b1;
	endfunction

	// Compare each popped result with the oldest prediction
	always @(posedge clk) begin : result_check
		bsd_pkg::result_t want;
		bit               bad;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				failures++;
				$display("%0t: unexpected result, expected none, got status %0d col %0d row %0d",
					$time, result.status, result.column, result.row);
			end else begin
				want = pending_results.pop_front();
				bad  = 1'b0;
				bad |= field_differs("status", 32'(want.status), 32'(result.status));
				bad |= field_differs("column", 32'(want.column), 32'(result.column));
				bad |= field_differs("row", 32'(want.row), 32'(result.row));
				bad |= field_differs("red", 32'(want.red), 32'(result.red));
				bad |= field_differs("green", 32'(want.green), 32'(result.green));
				bad |= field_differs("blue", 32'(want.blue), 32'(result.blue));
				bad |= field_differs("last_pixel", 32'(want.last_pixel),
					32'(result.last_pixel));
				if (bad) failures++;
				else if (want.status == bsd_pkg::ST_PIXEL) pixels_checked++;
				else errors_checked++;
			end
		end
	end

	// Stray bytes before any file, then swapped and broken magic
	task automatic test_magic();
		bmp_hdr_t d;
		send_file(good_header(1, 1, 0, 0, 0), 0, 5);
		d        = good_header(2, 1, 2, 0, 0);
		d.magic0 = bsd_pkg::MAGIC_1;
		d.magic1 = bsd_pkg::MAGIC_0;
		send_file(d, bsd_pkg::HEADER_LEN, 4);
		d.magic0 = bsd_pkg::MAGIC_0;
		d.magic1 = 8'hFF;
		send_file(d, 2, 3);
	endtask

	// Each header check, the first failing one winning, and a wrapping size sum
	task automatic test_header_checks();
		bmp_hdr_t d;
		d = good_header(2, 2, 2, 0, 0);
		d.total_size = d.total_size + 1;
		send_file(d, bsd_pkg::HEADER_LEN, 3);
		d = good_header(2, 2, 2, 0, 0);
		d.info_size = 32'd12;
		d.comp      = 32'd1;
		send_file(d, bsd_pkg::HEADER_LEN, 3);
		d = good_header(2, 2, 2, 0, 0);
		d.comp = 32'hFFFF_FFFF;
		send_file(d, bsd_pkg::HEADER_LEN, 0);
		d = good_header(2, 2, 2, 0, 0);
		d.planes = 16'd0;
		send_file(d, bsd_pkg::HEADER_LEN, 0);
		d = good_header(2, 2, 2, 0, 0);
		d.bpp   = 16'd32;
		d.width = '0;
		send_file(d, bsd_pkg::HEADER_LEN, 2);
		d = good_header(3, 2, 0, 0, 0);
		d.data_ofs   = 32'hFFFF_FFF0;
		d.total_size = d.psize + d.data_ofs;
		send_file(d, bsd_pkg::HEADER_LEN, image_bytes(3, 2, 0));
	endtask

	// Zero, oversize and most-negative dimensions; stride out of range
	task automatic test_geometry();
		bmp_hdr_t d;
		d = good_header(0, 2, 0, 0, 0);
		send_file(d, bsd_pkg::HEADER_LEN, 3);
		d = good_header(2, 0, 0, 0, 0);
		send_file(d, bsd_pkg::HEADER_LEN, 0);
		d = good_header(bsd_pkg::MAX_DIMENSION + 1, 1, 0, 1, 0);
		send_file(d, bsd_pkg::HEADER_LEN, 0);
		d = good_header(1, 1, 0, 0, 0);
		d.height = 32'h8000_0000;
		send_file(d, bsd_pkg::HEADER_LEN, 0);
		d = good_header(3, 2, 0, 0, 0);
		d.psize      = 2 * 9 - 1;
		d.total_size = d.psize + d.data_ofs;
		send_file(d, bsd_pkg::HEADER_LEN, 2);
		d = good_header(3, 2, 4, 0, 0);
		send_file(d, bsd_pkg::HEADER_LEN, 2);
	endtask

	// Every padding length, flipped rows and columns, a one-pixel image, junk after the end
	task automatic test_rows_and_padding();
		int unsigned p;
		for (p = 0; p < 4; p++)
			send_file(good_header(3, 2, p, p == 2, p[0]), bsd_pkg::HEADER_LEN,
				image_bytes(3, 2, p) + 3);
		send_file(good_header(1, 1, 0, 0, 1), bsd_pkg::HEADER_LEN, image_bytes(1, 1, 0));
	endtask

	// start_of_file arriving mid-header, mid-pixel and within row padding
	task automatic test_restarts();
		send_file(good_header(3, 2, 1, 0, 0), 30, 0);
		send_file(good_header(3, 2, 1, 0, 0), bsd_pkg::HEADER_LEN, 4);
		send_file(good_header(2, 2, 2, 0, 1), bsd_pkg::HEADER_LEN, 7);
		send_file(good_header(2, 3, 3, 0, 1), bsd_pkg::HEADER_LEN, image_bytes(2, 3, 3));
	endtask

	// Widest row and tallest column the block allows: header accepted, first pixels out
	task automatic test_largest_images();
		int unsigned p;
		p = $urandom_range(0, 3);
		send_file(good_header(bsd_pkg::MAX_DIMENSION, 1, p, 0, 0), bsd_pkg::HEADER_LEN, 30);
		send_file(good_header(1, bsd_pkg::MAX_DIMENSION, 1, 1, 1), bsd_pkg::HEADER_LEN, 30);
	endtask

	// Mostly well-formed small files with random content, the rest spoiled or noise
	task automatic test_random_files();
		bmp_hdr_t    d;
		defect_t     df;
		int unsigned w, h, pad;
		int          len, head, tail, start;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			w   = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
			h   = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
			pad = $urandom_range(0, 3);
			d   = good_header(w, h, pad, $urandom_range(0, 3) == 0,
				1'($urandom_range(0, 1)));
			len = image_bytes(w, h, pad);
			// slack below one row in the pixel size leaves the stride unchanged
			if ($urandom_range(0, 3) == 0) d.psize = d.psize + $urandom_range(0, h - 1);
			if ($urandom_range(0, 4) == 0) d.data_ofs = $urandom;
			d.total_size = d.psize + d.data_ofs;
			df   = ($urandom_range(0, 9) < 7) ? DF_NONE
				: defect_t'($urandom_range(DF_MAGIC, DF_NOISE));
			head = bsd_pkg::HEADER_LEN;
			tail = $urandom_range(0, 8);
			case (df)
				DF_NONE:   tail = len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
				DF_MAGIC:  if ($urandom_range(0, 1)) d.magic0 = 8'($urandom);
					else d.magic1 = 8'($urandom);
				DF_SIZE:   d.total_size = d.total_size + $urandom_range(1, 32'hFFFF_FFFE);
				DF_INFO:   d.info_size = $urandom_range(0, 1) ? $urandom : 32'd41;
				DF_COMP:   d.comp = $urandom_range(1, 32'hFFFF_FFFF);
				DF_PLANES: d.planes = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(2, 65535));
				DF_DEPTH:  d.bpp = $urandom_range(0, 1) ? 16'd32 : 16'($urandom);
				DF_DIM: begin
					case ($urandom_range(0, 3))
						0: d.width = '0;
						1: d.height = '0;
						2: d.width = $urandom_range(bsd_pkg::MAX_DIMENSION + 1, 32'h7FFF_FFFF);
						default: d.height = $urandom_range(0, 1) ? 32'h8000_0000 : $urandom;
					endcase
				end
				DF_STRIDE: begin
					d.psize = $urandom_range(0, 1) ? h * (3 * w) - 1
						: h * (3 * w + $urandom_range(4, 9));
					d.total_size = d.psize + d.data_ofs;
				end
				DF_CUT: begin
					if ($urandom_range(0, 1)) head = $urandom_range(1, bsd_pkg::HEADER_LEN - 1);
					tail = (head == bsd_pkg::HEADER_LEN) ? $urandom_range(0, len - 1) : 0;
				end
				default: begin
					head = 0;
					tail = $urandom_range(1, 30);
				end
			endcase
			send_file(d, head, tail);
		end
	endtask

	initial begin : run_limit
		#(RUN_LIMIT_NS);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : main
		int waited;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_magic();
		test_header_checks();
		test_geometry();
		test_rows_and_padding();
		test_restarts();
		test_largest_images();
		test_random_files();

		@(negedge clk);
		push <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			failures++;
			$display("%0t: %0d predicted results never arrived", $time, pending_results.size());
		end

		$display("Decoded %0d files from %0d bytes sent, %0d bytes taken by the parser.",
			files_sent, bytes_sent, bytes_taken);
		$display("Checked %0d pixels and %0d error reports, %0d mismatching results.",
			pixels_checked, errors_checked, failures);
		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
